[hdl/lapf_pkg.sv]
// ----------------------------------------------------------------------------
// lapf_pkg
// Shared sizes, register indexes and word layouts for the after-pulse filter.
// ----------------------------------------------------------------------------
package lapf_pkg;

  localparam int MAX_RETURNS   = 32;
  localparam int SAMPLE_BITS   = 10;
  localparam int FRACTION_BITS = 6;

  localparam int IDX_W  = $clog2(MAX_RETURNS);
  localparam int CNT_W  = $clog2(MAX_RETURNS + 1);
  localparam int TIME_W = 16;
  localparam int AMP_W  = SAMPLE_BITS + FRACTION_BITS;
  localparam int CHAN_W = 3;
  localparam int NUM_CHAN = 8;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_TIME_BOUND   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_TIME_BOUND   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE_DROP_MIN = 2'd3;
  localparam int CFG_DATA_W = 17;

  localparam logic [NUM_CHAN-1:0] CHANNEL_ENABLE_RESET = 8'd0;
  localparam logic [TIME_W-1:0]   LOWER_BOUND_RESET    = 16'd1280;
  localparam logic [TIME_W-1:0]   UPPER_BOUND_RESET    = 16'd2560;
  localparam logic signed [CFG_DATA_W-1:0] DROP_MIN_RESET = 17'sd0;

  // Word layouts.
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;
  localparam int MEM_W      = TIME_W + AMP_W;

  // Sequencer states.
  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] ST_LOAD     = 2'd0;
  localparam logic [ST_W-1:0] ST_RD_BEST  = 2'd1;
  localparam logic [ST_W-1:0] ST_RD_AFTER = 2'd2;
  localparam logic [ST_W-1:0] ST_DECIDE   = 2'd3;

  // Linear interpolation between two samples, scaled by 2^FRACTION_BITS.
  function automatic logic [AMP_W-1:0] interp_amp(
    input logic [FRACTION_BITS-1:0] frac,
    input logic [SAMPLE_BITS-1:0]   s0,
    input logic [SAMPLE_BITS-1:0]   s1
  );
    logic [FRACTION_BITS:0] w0;
    logic [AMP_W-1:0]       p0;
    logic [AMP_W-1:0]       p1;
    w0 = (FRACTION_BITS+1)'(1 << FRACTION_BITS) - {1'b0, frac};
    p0 = AMP_W'(s0) * AMP_W'(w0);
    p1 = AMP_W'(s1) * AMP_W'(frac);
    return p0 + p1;
  endfunction

endpackage

[hdl/lidar_after_pulse_filter.sv]
// ----------------------------------------------------------------------------
// lidar_after_pulse_filter
// Flags the after-pulse return of one shot on one channel for invalidation.
// ----------------------------------------------------------------------------
// Returns are taken back to back while the sequencer loads. After the last
// return of a shot the return store is read twice through its one read
// port and the decision is made, with the input not ready throughout; the
// result word is registered at the decision. A result still waiting in
// the output register and not taken holds the sequencer at the decision.
// Reset restores the registers to defaults; the return store is not cleared.
// ----------------------------------------------------------------------------
module lidar_after_pulse_filter (
  input  logic                                clk,
  input  logic                                rst,
  // Input words. tdata from bit 0: channel_index[2:0], is_land[3],
  // return_valid[4], pulse_time[20:5], sample_at_floor[30:21],
  // sample_after_floor[40:31], zero fill [47:41].
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lapf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic                                s_axis_tlast,
  // Result words. tdata from bit 0: invalidate[0],
  // invalid_return_index[5:1], strongest_index[10:6], result_channel[13:11],
  // zero fill [15:14].
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lapf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lapf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lapf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IDX_W  = lapf_pkg::IDX_W;
  localparam int CNT_W  = lapf_pkg::CNT_W;
  localparam int TIME_W = lapf_pkg::TIME_W;
  localparam int AMP_W  = lapf_pkg::AMP_W;
  localparam int CHAN_W = lapf_pkg::CHAN_W;
  localparam int SB     = lapf_pkg::SAMPLE_BITS;
  localparam int FB     = lapf_pkg::FRACTION_BITS;

  // Configuration registers. Writes are always taken.
  logic [lapf_pkg::NUM_CHAN-1:0]          channel_enable;
  logic [TIME_W-1:0]                      lower_time_bound;
  logic [TIME_W-1:0]                      upper_time_bound;
  logic signed [lapf_pkg::CFG_DATA_W-1:0] amplitude_drop_min;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable     <= lapf_pkg::CHANNEL_ENABLE_RESET;
      lower_time_bound   <= lapf_pkg::LOWER_BOUND_RESET;
      upper_time_bound   <= lapf_pkg::UPPER_BOUND_RESET;
      amplitude_drop_min <= lapf_pkg::DROP_MIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        lapf_pkg::REG_CHANNEL_ENABLE:
          channel_enable <= cfg_data[lapf_pkg::NUM_CHAN-1:0];
        lapf_pkg::REG_LOWER_TIME_BOUND:
          lower_time_bound <= cfg_data[TIME_W-1:0];
        lapf_pkg::REG_UPPER_TIME_BOUND:
          upper_time_bound <= cfg_data[TIME_W-1:0];
        lapf_pkg::REG_AMPLITUDE_DROP_MIN:
          amplitude_drop_min <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Unpack the input word.
  logic [CHAN_W-1:0] in_chan;
  logic              in_land;
  logic              in_valid_ret;
  logic [TIME_W-1:0] in_ip;
  logic [SB-1:0]     in_s0;
  logic [SB-1:0]     in_s1;

  assign in_chan      = s_axis_tdata[2:0];
  assign in_land      = s_axis_tdata[3];
  assign in_valid_ret = s_axis_tdata[4];
  assign in_ip        = s_axis_tdata[20:5];
  assign in_s0        = s_axis_tdata[30:21];
  assign in_s1        = s_axis_tdata[40:31];

  // Sequencer. Returns load in ST_LOAD; the last one starts the readback.
  logic [lapf_pkg::ST_W-1:0] state;
  logic                      in_accept;
  logic                      out_free;

  assign s_axis_tready = (state == lapf_pkg::ST_LOAD);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Shot trackers. The after pulse is the next valid return after the
  // strongest, and the test needs it to be the last valid return, which is
  // the same as exactly one valid return having arrived after the strongest.
  // after_best counts those, saturating at two.
  logic [CNT_W-1:0]  return_count;
  logic              any_valid;
  logic [IDX_W-1:0]  last_valid_index;
  logic [AMP_W-1:0]  best_amplitude;
  logic [IDX_W-1:0]  best_index;
  logic [1:0]        after_best;

  logic              store_ok;
  logic              take;
  logic              becomes_best;
  logic [AMP_W-1:0]  amp;
  logic [IDX_W-1:0]  slot;
  logic [1:0]        after_best_next;
  logic              any_valid_next;
  logic [IDX_W-1:0]  best_index_next;

  assign store_ok = (return_count < CNT_W'(lapf_pkg::MAX_RETURNS));
  assign slot     = return_count[IDX_W-1:0];
  assign amp      = lapf_pkg::interp_amp(in_ip[FB-1:0], in_s0, in_s1);
  assign take     = store_ok && in_valid_ret;
  assign becomes_best = take && (!any_valid || (amp > best_amplitude));
  assign any_valid_next  = any_valid || take;
  assign best_index_next = becomes_best ? slot : best_index;

  always_comb begin
    after_best_next = after_best;
    if (becomes_best) begin
      after_best_next = 2'd0;
    end else if (take && (after_best != 2'd2)) begin
      after_best_next = after_best + 2'd1;
    end
  end

  // Return store: time in the low half, amplitude in the high half.
  logic [lapf_pkg::MEM_W-1:0] ret_mem [lapf_pkg::MAX_RETURNS];
  logic [lapf_pkg::MEM_W-1:0] rd_data;
  logic [IDX_W-1:0]           rd_addr;
  logic                       wr_en;

  assign wr_en   = in_accept && store_ok;
  assign rd_addr = (state == lapf_pkg::ST_RD_BEST) ? best_index : last_valid_index;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ret_mem[slot] <= {amp, in_ip};
    end
    rd_data <= ret_mem[rd_addr];
  end

  // Held across the readback.
  logic              filt_go;
  logic [IDX_W-1:0]  strongest_out;
  logic [CHAN_W-1:0] chan_hold;
  logic [TIME_W-1:0] best_time;

  // Decision on the after-pulse entry now in rd_data.
  logic signed [TIME_W:0] tdiff;
  logic signed [AMP_W:0]  drop;
  logic                   hit;

  assign tdiff = $signed({1'b0, rd_data[TIME_W-1:0]}) - $signed({1'b0, best_time});
  assign drop  = $signed({1'b0, best_amplitude})
               - $signed({1'b0, rd_data[lapf_pkg::MEM_W-1:TIME_W]});
  assign hit   = filt_go
               && (tdiff >= $signed({1'b0, lower_time_bound}))
               && (tdiff <= $signed({1'b0, upper_time_bound}))
               && (drop >= amplitude_drop_min);

  // Output register; the next shot may load while a result waits.
  logic                        out_valid;
  logic [lapf_pkg::OUT_DATA_W-1:0] out_data;

  assign out_free      = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= lapf_pkg::ST_LOAD;
      return_count     <= '0;
      any_valid        <= 1'b0;
      last_valid_index <= '0;
      best_amplitude   <= '0;
      best_index       <= '0;
      after_best       <= '0;
      out_valid        <= 1'b0;
    end else begin
      // A new result replaces the one taken on the same edge.
      if ((state == lapf_pkg::ST_DECIDE) && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        lapf_pkg::ST_LOAD: begin
          if (in_accept) begin
            if (store_ok) begin
              return_count <= return_count + CNT_W'(1);
            end
            if (take) begin
              last_valid_index <= slot;
            end
            if (becomes_best) begin
              best_amplitude <= amp;
            end
            best_index <= best_index_next;
            any_valid  <= any_valid_next;
            after_best <= after_best_next;
            if (s_axis_tlast) begin
              state <= lapf_pkg::ST_RD_BEST;
            end
          end
        end
        lapf_pkg::ST_RD_BEST: begin
          state <= lapf_pkg::ST_RD_AFTER;
        end
        lapf_pkg::ST_RD_AFTER: begin
          state <= lapf_pkg::ST_DECIDE;
        end
        lapf_pkg::ST_DECIDE: begin
          if (out_free) begin
            return_count     <= '0;
            any_valid        <= 1'b0;
            last_valid_index <= '0;
            best_amplitude   <= '0;
            best_index       <= '0;
            after_best       <= '0;
            state            <= lapf_pkg::ST_LOAD;
          end
        end
        default: state <= lapf_pkg::ST_LOAD;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept && s_axis_tlast) begin
      filt_go       <= channel_enable[in_chan] && in_land && (after_best_next == 2'd1);
      strongest_out <= any_valid_next ? best_index_next : '0;
      chan_hold     <= in_chan;
    end
    if (state == lapf_pkg::ST_RD_AFTER) begin
      best_time <= rd_data[TIME_W-1:0];
    end
    if ((state == lapf_pkg::ST_DECIDE) && out_free) begin
      out_data <= {2'b00, chan_hold, strongest_out,
                   (hit ? last_valid_index : IDX_W'(0)), hit};
    end
  end

endmodule

[bench/lidar_after_pulse_filter_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lidar_after_pulse_filter_tb
// Self-checking bench for the after-pulse filter: hand-picked and random shots
// under several register settings, checked word by word against a shot tracker.
// ----------------------------------------------------------------------------
module lidar_after_pulse_filter_tb;
  import lapf_pkg::*;

  // A run is declared hung once this many cycles pass with no word moving.
  localparam int STUCK_LIMIT   = 4000;
  // Quiet cycles before a register write and at the very end.
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_PRINTED   = 40;

  // One return of a shot, as it travels on the input stream.
  typedef struct {
    logic [CHAN_W-1:0]      chan;
    logic                   land;
    logic                   ok;
    logic [TIME_W-1:0]      ip;
    logic [SAMPLE_BITS-1:0] s0;
    logic [SAMPLE_BITS-1:0] s1;
    logic                   last;
  } shot_return_t;

  // The decision that closes a shot.
  typedef struct {
    logic              inv;
    logic [IDX_W-1:0]  inv_idx;
    logic [IDX_W-1:0]  best;
    logic [CHAN_W-1:0] chan;
  } verdict_t;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  lidar_after_pulse_filter i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Words waiting to be sent, and decisions waiting to come back.
  shot_return_t return_queue[$];
  verdict_t     verdict_queue[$];
  int           mismatch_count = 0;

  // The bench's own copy of the registers, updated as each write is taken.
  logic [NUM_CHAN-1:0]          chan_enable = CHANNEL_ENABLE_RESET;
  logic [TIME_W-1:0]            t_lo        = LOWER_BOUND_RESET;
  logic [TIME_W-1:0]            t_hi        = UPPER_BOUND_RESET;
  logic signed [CFG_DATA_W-1:0] drop_min    = DROP_MIN_RESET;

  // Shot tracker state: the stored returns of the shot in progress.
  logic [TIME_W-1:0] shot_time [MAX_RETURNS];
  logic [AMP_W-1:0]  shot_amp  [MAX_RETURNS];
  logic              shot_ok   [MAX_RETURNS];
  int                shot_len      = 0;
  int                valid_seen    = 0;
  int                last_valid_at = 0;
  int                best_at       = 0;
  logic [AMP_W-1:0]  best_amp      = '0;

  // Handshake bookkeeping shared by the driver, the ready driver and the
  // monitor. The drivers run on the falling edge and the monitor on the rising one, so no race arises.
  shot_return_t cur_return;
  bit           in_taken     = 1'b0;
  bit           out_taken    = 1'b0;
  bit           moved;
  int           in_gap       = 0;
  int           in_quiet     = 0;
  int           out_stall    = 0;
  int           out_quiet    = 0;
  int           stuck_cycles = 0;

  task automatic log_mismatch(input string what, input logic [15:0] got,
                              input logic [15:0] want);
    if (mismatch_count < MAX_PRINTED)
      $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_CHANNEL_ENABLE:     chan_enable = val[NUM_CHAN-1:0];
      REG_LOWER_TIME_BOUND:   t_lo = val[TIME_W-1:0];
      REG_UPPER_TIME_BOUND:   t_hi = val[TIME_W-1:0];
      REG_AMPLITUDE_DROP_MIN: drop_min = val;
      default: ;
    endcase
  endfunction

  // Stores one accepted return and, on the last one of a shot, works out the
  // decision the block must issue and queues it.
  function automatic void track_return(input shot_return_t r);
    logic [AMP_W-1:0] amp;
    verdict_t         v;
    int               frac;
    int               nxt;
    int               k;
    int               tdiff;
    int               drop;
    int               thr;
    frac = int'(r.ip) & ((1 << FRACTION_BITS) - 1);
    amp  = AMP_W'(int'(r.s0) * ((1 << FRACTION_BITS) - frac) + int'(r.s1) * frac);
    // Returns beyond the store's depth are dropped but a last flag still counts.
    if (shot_len < MAX_RETURNS) begin
      shot_time[shot_len] = r.ip;
      shot_amp[shot_len]  = amp;
      shot_ok[shot_len]   = r.ok;
      if (r.ok) begin
        // Strictly greater, so the earliest of equal amplitudes stays strongest.
        if (valid_seen == 0 || amp > best_amp) begin
          best_amp = amp;
          best_at  = shot_len;
        end
        valid_seen++;
        last_valid_at = shot_len;
      end
      shot_len++;
    end
    if (!r.last) return;

    // Channel and land come from the closing word only.
    v.inv     = 1'b0;
    v.inv_idx = '0;
    v.best    = IDX_W'(best_at);
    v.chan    = r.chan;
    if (chan_enable[r.chan] && r.land && valid_seen >= 2 && best_at != last_valid_at) begin
      nxt = last_valid_at;
      for (k = best_at + 1; k < shot_len; k++) begin
        if (shot_ok[k]) begin
          nxt = k;
          break;
        end
      end
      // The after pulse must be the very next valid return and the last one.
      if (nxt == last_valid_at) begin
        tdiff = int'(shot_time[nxt]) - int'(shot_time[best_at]);
        if (tdiff >= int'(t_lo) && tdiff <= int'(t_hi)) begin
          drop = int'(best_amp) - int'(shot_amp[nxt]);
          thr  = drop_min;
          if (drop >= thr) begin
            v.inv     = 1'b1;
            v.inv_idx = IDX_W'(nxt);
          end
        end
      end
    end
    verdict_queue.push_back(v);

    shot_len      = 0;
    valid_seen    = 0;
    last_valid_at = 0;
    best_at       = 0;
    best_amp      = '0;
    for (k = 0; k < MAX_RETURNS; k++) shot_ok[k] = 1'b0;
  endfunction

  task automatic check_verdict(input logic [OUT_DATA_W-1:0] w);
    verdict_t want;
    if (verdict_queue.size() == 0) begin
      log_mismatch("result word with no decision pending", w, 16'h0);
      return;
    end
    want = verdict_queue.pop_front();
    if (w[0] !== want.inv)         log_mismatch("invalidate", w[0], want.inv);
    if (w[5:1] !== want.inv_idx)   log_mismatch("invalid_return_index", w[5:1], want.inv_idx);
    if (w[10:6] !== want.best)     log_mismatch("strongest_index", w[10:6], want.best);
    if (w[13:11] !== want.chan)    log_mismatch("result_channel", w[13:11], want.chan);
  endtask

  // Idle lengths: mostly none, often a few cycles, now and then a long one.
  function automatic int draw_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_return(input logic [CHAN_W-1:0] ch, input logic land,
                                      input logic ok, input logic [TIME_W-1:0] ip,
                                      input logic [SAMPLE_BITS-1:0] s0,
                                      input logic [SAMPLE_BITS-1:0] s1, input logic last);
    shot_return_t r;
    r = '{ch, land, ok, ip, s0, s1, last};
    return_queue.push_back(r);
  endfunction

  // A return with random time and samples. Words before the last sometimes
  // carry a stray channel or land bit, which the block must ignore.
  function automatic void push_filler(input logic [CHAN_W-1:0] ch, input logic land,
                                      input logic ok, input logic last, input int cap);
    logic [CHAN_W-1:0] c;
    logic              l;
    c = ch;
    l = land;
    if (!last && $urandom_range(0, 7) == 0) begin
      c = CHAN_W'($urandom_range(0, 7));
      l = 1'($urandom_range(0, 1));
    end
    push_return(c, l, ok, TIME_W'($urandom), SAMPLE_BITS'($urandom_range(0, cap)),
                SAMPLE_BITS'($urandom_range(0, cap)), last);
  endfunction

  // A well-formed shot: earlier returns, a strong return, invalid returns, the
  // after pulse, invalid trailers. The offset is aimed at the time bounds,
  // and now and then a valid return is slipped in between to break the shape.
  function automatic int add_after_pulse_shot();
    logic [CHAN_W-1:0]      ch;
    logic                   land;
    logic                   tie;
    logic [SAMPLE_BITS-1:0] h0;
    logic [SAMPLE_BITS-1:0] h1;
    logic [SAMPLE_BITS-1:0] a0;
    logic [SAMPLE_BITS-1:0] a1;
    int                     pre;
    int                     mid;
    int                     post;
    int                     off;
    int                     ip_s;
    int                     k;
    ch   = CHAN_W'($urandom_range(0, 7));
    land = ($urandom_range(0, 4) != 0);
    tie  = ($urandom_range(0, 5) == 0);
    // A few shots run past the store's depth.
    pre  = ($urandom_range(0, 24) == 0) ? $urandom_range(20, 36) : $urandom_range(0, 3);
    mid  = $urandom_range(0, 3);
    post = $urandom_range(0, 2);
    case ($urandom_range(0, 9))
      0:       off = int'(t_lo) - 1;
      1:       off = int'(t_lo);
      2:       off = int'(t_hi);
      3:       off = int'(t_hi) + 1;
      8:       off = -int'($urandom_range(1, 4000));
      9:       off = int'($urandom_range(0, 65535));
      default: off = (t_lo <= t_hi) ? int'($urandom_range(t_lo, t_hi))
                                    : int'($urandom_range(0, 4000));
    endcase
    // Equal samples at equal fractions give a drop of exactly zero.
    if (tie) off = off & ~63;
    if (off > 65535) off = 65535;
    ip_s = (off >= 0) ? $urandom_range(0, 65535 - off) : $urandom_range(-off, 65535);
    h0 = SAMPLE_BITS'($urandom_range(400, 1023));
    h1 = SAMPLE_BITS'($urandom_range(400, 1023));
    if (tie) begin
      a0 = h0;
      a1 = h1;
    end else if ($urandom_range(0, 3) == 0) begin
      a0 = SAMPLE_BITS'($urandom);
      a1 = SAMPLE_BITS'($urandom);
    end else begin
      a0 = SAMPLE_BITS'($urandom_range(0, 500));
      a1 = SAMPLE_BITS'($urandom_range(0, 500));
    end
    for (k = 0; k < pre; k++) push_filler(ch, land, $urandom_range(0, 2) != 0, 1'b0, 600);
    push_return(ch, land, 1'b1, TIME_W'(ip_s), h0, h1, 1'b0);
    for (k = 0; k < mid; k++) push_filler(ch, land, $urandom_range(0, 5) == 0, 1'b0, 1023);
    push_return(ch, land, 1'b1, TIME_W'(ip_s + off), a0, a1, post == 0);
    for (k = 0; k < post; k++) push_filler(ch, land, 1'b0, k == post - 1, 1023);
    return pre + mid + post + 2;
  endfunction

  // A shot of fully random words.
  function automatic int add_noise_shot();
    int n;
    int k;
    n = ($urandom_range(0, 24) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 6);
    for (k = 0; k < n; k++)
      push_return(CHAN_W'($urandom), 1'($urandom), 1'($urandom), TIME_W'($urandom),
                  SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom), k == n - 1);
    return n;
  endfunction

  // Waits until every word is sent and every decision has come back.
  task automatic drain();
    while (return_queue.size() > 0 || s_axis_tvalid || verdict_queue.size() > 0)
      @(posedge clk);
  endtask

  task automatic queue_random(input int n_words);
    int queued;
    queued = 0;
    while (queued < n_words)
      queued += ($urandom_range(0, 9) < 7) ? add_after_pulse_shot() : add_noise_shot();
    drain();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Called only with the block drained; the pause lets any scan finish.
  task automatic set_config(input logic [NUM_CHAN-1:0] en, input int lo, input int hi,
                            input int drop);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_CHANNEL_ENABLE, CFG_DATA_W'(en));
    write_reg(REG_LOWER_TIME_BOUND, CFG_DATA_W'(lo));
    write_reg(REG_UPPER_TIME_BOUND, CFG_DATA_W'(hi));
    write_reg(REG_AMPLITUDE_DROP_MIN, CFG_DATA_W'(drop));
  endtask

  // Hand-picked shots, run with all channels on, bounds 1280..2560, drop 0.
  function automatic void queue_directed();
    // Plain after pulse behind an invalid return: flagged.
    push_return(3'd3, 1'b1, 1'b1, 16'd1000, 10'd1000, 10'd1000, 1'b0);
    push_return(3'd3, 1'b1, 1'b0, 16'd1500, 10'd700, 10'd700, 1'b0);
    push_return(3'd3, 1'b1, 1'b1, 16'd2500, 10'd200, 10'd200, 1'b1);
    // Equal amplitudes: the first keeps the strongest place, zero drop passes.
    push_return(3'd5, 1'b1, 1'b1, 16'd64, 10'd500, 10'd500, 1'b0);
    push_return(3'd5, 1'b1, 1'b1, 16'd1472, 10'd500, 10'd500, 1'b1);
    // The next valid return is not the last valid one.
    push_return(3'd2, 1'b1, 1'b1, 16'd100, 10'd900, 10'd900, 1'b0);
    push_return(3'd2, 1'b1, 1'b1, 16'd1500, 10'd300, 10'd300, 1'b0);
    push_return(3'd2, 1'b1, 1'b1, 16'd1600, 10'd200, 10'd200, 1'b1);
    // Negative time offset.
    push_return(3'd1, 1'b1, 1'b1, 16'd5000, 10'd900, 10'd900, 1'b0);
    push_return(3'd1, 1'b1, 1'b1, 16'd3000, 10'd100, 10'd100, 1'b1);
    // Land bit cleared on the closing word only.
    push_return(3'd4, 1'b1, 1'b1, 16'd1000, 10'd1000, 10'd1000, 1'b0);
    push_return(3'd4, 1'b0, 1'b1, 16'd2500, 10'd200, 10'd200, 1'b1);
    // Channel taken from the closing word.
    push_return(3'd6, 1'b1, 1'b1, 16'd1000, 10'd800, 10'd800, 1'b0);
    push_return(3'd0, 1'b1, 1'b1, 16'd2400, 10'd100, 10'd100, 1'b1);
    // No valid return, then a single valid return.
    push_return(3'd7, 1'b1, 1'b0, 16'hFFFF, 10'h3FF, 10'h3FF, 1'b1);
    push_return(3'd7, 1'b1, 1'b1, 16'd0, 10'd0, 10'd0, 1'b1);
    // The strongest is the last valid return.
    push_return(3'd0, 1'b1, 1'b1, 16'd100, 10'd100, 10'd100, 1'b0);
    push_return(3'd0, 1'b1, 1'b1, 16'd1500, 10'd900, 10'd900, 1'b1);
    // Extreme times and samples, far outside the bounds.
    push_return(3'd7, 1'b1, 1'b1, 16'd0, 10'h3FF, 10'd0, 1'b0);
    push_return(3'd7, 1'b1, 1'b1, 16'hFFFF, 10'd0, 10'h3FF, 1'b1);
    // Offset exactly on the upper bound.
    push_return(3'd2, 1'b1, 1'b1, 16'd0, 10'd600, 10'd600, 1'b0);
    push_return(3'd2, 1'b1, 1'b1, 16'd2560, 10'd100, 10'd100, 1'b1);
  endfunction

  // Input driver: presents the next word on the falling edge once the
  // previous one has been taken, with random gaps between words and an
  // occasional run of back-to-back words.
  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (return_queue.size() > 0) begin
        cur_return = return_queue.pop_front();
        s_axis_tdata <= {7'd0, cur_return.s1, cur_return.s0, cur_return.ip,
                         cur_return.ok, cur_return.land, cur_return.chan};
        s_axis_tlast  <= cur_return.last;
        s_axis_tvalid <= 1'b1;
        if (in_quiet > 0) begin
          in_quiet--;
          in_gap = 0;
        end else begin
          if ($urandom_range(0, 149) == 0) in_quiet = $urandom_range(30, 120);
          in_gap = draw_idle();
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure: ready drops at random, whether or not a
  // result is waiting.
  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken || $urandom_range(0, 9) == 0) begin
        out_taken = 1'b0;
        if (out_quiet > 0) begin
          out_quiet--;
          out_stall = 0;
        end else begin
          if ($urandom_range(0, 149) == 0) out_quiet = $urandom_range(30, 120);
          out_stall = draw_idle();
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: checks each result word, feeds each accepted input word to the
  // shot tracker, and runs the watchdog. Results are handled first; a
  // result can never belong to a word taken on the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      moved = 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        check_verdict(m_axis_tdata);
        out_taken = 1'b1;
        moved     = 1'b1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        track_return(cur_return);
        in_taken = 1'b1;
        moved    = 1'b1;
      end
      if (cfg_valid && cfg_ready) moved = 1'b1;
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Test sequence: a stretch under the reset settings, the hand-picked
  // shots, then random shots under a series of register settings that
  // includes the extremes.
  initial begin
    int lo;
    int hi;
    int drop;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings leave every channel off, so nothing may be flagged.
    queue_random(60);

    set_config(8'hFF, 1280, 2560, 0);
    queue_directed();
    queue_random(250);

    set_config(8'h00, 1280, 2560, 0);
    queue_random(120);

    // Widest bounds and the most lenient drop.
    set_config(8'hFF, 0, 65535, -65535);
    queue_random(200);

    // Crossed bounds: nothing can pass.
    set_config(8'hFF, 65535, 0, 0);
    queue_random(120);

    // Zero-width window at zero offset, random channel mask.
    set_config(NUM_CHAN'($urandom), 0, 0, 0);
    queue_random(150);

    // Drop threshold beyond any reachable amplitude.
    set_config(8'hFF, 1280, 2560, 65535);
    queue_random(150);

    repeat (3) begin
      lo   = $urandom_range(0, 3000);
      hi   = lo + $urandom_range(0, 3000);
      drop = int'($urandom_range(0, 12000)) - 6000;
      set_config(NUM_CHAN'($urandom), lo, hi, drop);
      queue_random(200);
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[lidar_after_pulse_filter.f]
hdl/lapf_pkg.sv
hdl/lidar_after_pulse_filter.sv
bench/lidar_after_pulse_filter_tb.sv
